// ----- sv/lipo_charge_state_estimator_defines.svh -----
// Assertion macros for the charge state estimator.
// No dependencies.
`ifndef LIPO_CHARGE_STATE_ESTIMATOR_DEFINES_SVH
`define LIPO_CHARGE_STATE_ESTIMATOR_DEFINES_SVH
// Assert that a condition implies a consequence on the same edge.
`define LCSE_ASSERT_IMPL(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("label failed");
// Assert that a condition implies a consequence on the next edge.
`define LCSE_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("label failed");
`endif

// ----- sv/lcse_pkg.sv -----
// Shared types and constants of the charge state estimator.
// No dependencies.
package lcse_pkg;
	localparam int AvgSamples = 16;
	localparam int AdcBits = 12;
	localparam int CntW = $clog2(AvgSamples);
	localparam int SumW = AdcBits + CntW;
	localparam logic [12:0] OnMv = 13'd4180;
	localparam logic [12:0] OffMv = 13'd4050;
	localparam logic [12:0] JumpMinMv = 13'd3900;
	localparam logic [12:0] PrevValidMv = 13'd500;
	localparam logic [12:0] MvMax = 13'd8191;
	localparam logic [31:0] MsPerPct = 32'd60000;
	localparam logic [7:0] ChargeCap = 8'd99;

	localparam logic [1:0] REG_SCALE = 2'd0;
	localparam logic [1:0] REG_STORED = 2'd1;
	localparam logic [1:0] REG_STATS = 2'd2;
	localparam logic [1:0] REG_INTERVAL = 2'd3;

	typedef struct packed {
		logic load;     // latch request, add sample
		logic scale;    // multiply average by scale
		logic decide;   // voltage, charger, curve multiply
		logic finish;   // percent and result
	} cmd_t;

	typedef struct packed {
		logic done_avg;  // request completes an average
	} sts_t;

	// curve point i (descending voltage), segment i is between i and i+1
	function automatic logic [12:0] curve_mv(input logic [3:0] i);
		unique case (i)
			4'd0: curve_mv = 13'd4200;
			4'd1: curve_mv = 13'd4100;
			4'd2: curve_mv = 13'd4000;
			4'd3: curve_mv = 13'd3900;
			4'd4: curve_mv = 13'd3800;
			4'd5: curve_mv = 13'd3700;
			4'd6: curve_mv = 13'd3600;
			4'd7: curve_mv = 13'd3500;
			4'd8: curve_mv = 13'd3400;
			4'd9: curve_mv = 13'd3300;
			default: curve_mv = 13'd3000;
		endcase
	endfunction

	function automatic logic [6:0] curve_pct(input logic [3:0] i);
		unique case (i)
			4'd0: curve_pct = 7'd100;
			4'd1: curve_pct = 7'd95;
			4'd2: curve_pct = 7'd88;
			4'd3: curve_pct = 7'd78;
			4'd4: curve_pct = 7'd65;
			4'd5: curve_pct = 7'd50;
			4'd6: curve_pct = 7'd35;
			4'd7: curve_pct = 7'd20;
			4'd8: curve_pct = 7'd10;
			4'd9: curve_pct = 7'd5;
			default: curve_pct = 7'd0;
		endcase
	endfunction
endpackage

// ----- sv/lipo_charge_state_estimator.sv -----
// Top level of the LiPo charge state estimator.
// Depends on lcse_pkg, lcse_ctrl, lcse_datapath and the defines header.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | kind, raw_sample, now_ms, add_seconds
//  out     | out_valid/ out_ready | percent, voltage_mv, charging, updated,
//          |                      | cycles, session_seconds, total_seconds, save_request
//  cfg     | cfg_we               | cfg_idx, cfg_data
//
// A request that completes an average passes through load, scale multiply,
// decide with curve multiply and finish; any other request skips the decide step.
// The next request is taken in the cycle its predecessor's result is taken.
// Reset clears all counters and loads register reset values; a stalled
// output holds the result and the sequencer waits.
`include "lipo_charge_state_estimator_defines.svh"
module lipo_charge_state_estimator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [17:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [11:0]       raw_sample,
	input  logic [31:0]       now_ms,
	input  logic [15:0]       add_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] percent,
	output logic [12:0]       voltage_mv,
	output logic              charging,
	output logic              updated,
	output logic [31:0]       cycles,
	output logic [31:0]       session_seconds,
	output logic [31:0]       total_seconds,
	output logic              save_request
);
	lcse_pkg::cmd_t cmd;
	lcse_pkg::sts_t sts;

	// sequencer
	lcse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	// arithmetic and state
	lcse_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.kind(kind), .raw_sample(raw_sample), .now_ms(now_ms), .add_seconds(add_seconds),
		.percent(percent), .voltage_mv(voltage_mv), .charging(charging),
		.updated(updated), .cycles(cycles), .session_seconds(session_seconds),
		.total_seconds(total_seconds), .save_request(save_request)
	);

	// a charging result never reports more than the cap
	`LCSE_ASSERT_IMPL(a_cap, out_valid && charging && updated, percent <= 8'sd99)
	// a result held under stall stays put
	`LCSE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(cycles))
	// no request is taken mid-computation
	`LCSE_ASSERT_IMPL(a_busy, in_ready, out_valid || !$past(in_valid && in_ready))
endmodule

// ----- sv/lcse_ctrl.sv -----
// Sequencer of the charge state estimator.
// Depends on lcse_pkg.
module lcse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lcse_pkg::sts_t   sts,
	output lcse_pkg::cmd_t   cmd
);
	typedef enum logic [2:0] {S_IDLE, S_SCALE, S_DECIDE, S_FINISH, S_OUT} state_t;
	state_t state_q;

	// accept a new request once the previous result is taken or while it is taken
	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.scale = (state_q == S_SCALE);
		cmd.decide = (state_q == S_DECIDE);
		cmd.finish = (state_q == S_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= sts.done_avg ? S_DECIDE : S_FINISH;
				end
				S_DECIDE: state_q <= S_FINISH;
				S_FINISH: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_SCALE : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/lcse_datapath.sv -----
// Datapath of the charge state estimator: averaging, scaling, charger
// detection, percent estimate and runtime counters. Depends on lcse_pkg.
module lcse_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcse_pkg::cmd_t       cmd,
	output lcse_pkg::sts_t       sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [17:0]          cfg_data,
	input  logic                 kind,
	input  logic [11:0]          raw_sample,
	input  logic [31:0]          now_ms,
	input  logic [15:0]          add_seconds,
	output logic signed [7:0]    percent,
	output logic [12:0]          voltage_mv,
	output logic                 charging,
	output logic                 updated,
	output logic [31:0]          cycles,
	output logic [31:0]          session_seconds,
	output logic [31:0]          total_seconds,
	output logic                 save_request
);
	localparam int SW = lcse_pkg::SumW;
	localparam int CW = lcse_pkg::CntW;

	logic [17:0] scale_q;
	logic signed [7:0] known_q, cur_pct_q, base_q;
	logic stats_q;
	logic [15:0] interval_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic [12:0] prev_q;
	logic chg_q;
	logic [31:0] start_q, cyc_q, sess_q, tot_q, last_save_q;

	logic kind_q, done_q, save_q, upd_q;
	logic [31:0] now_q;
	logic [15:0] secs_q;
	logic [31:0] interval_ms_q;
	logic [29:0] prod_q;
	logic [12:0] mv_q;
	logic [14:0] interp_q;
	logic [12:0] span_q;
	logic [6:0] lo_pct_q;
	logic clamp_hi_q, clamp_lo_q;
	logic [31:0] elapsed_q;

	// configuration writes
	logic signed [7:0] cfg_pct;
	always_comb begin
		cfg_pct = cfg_data[7:0];
		if (cfg_pct < -8'sd1 || cfg_pct > 8'sd100) cfg_pct = -8'sd1;
	end

	// average count; AvgSamples is a power of two so divide is a shift
	logic [SW-1:0] sum_next;
	assign sum_next = sum_q + SW'(raw_sample);
	logic [lcse_pkg::AdcBits-1:0] avg;
	assign avg = sum_q[SW-1:CW];

	// decide step combinational
	logic [12:0] mv;
	logic prev_ok, jump, drop, chg_next, start;
	logic [13:0] up_d, dn_d;
	logic [3:0] seg;
	always_comb begin
		mv = (prod_q[29:16] > 14'(lcse_pkg::MvMax)) ? lcse_pkg::MvMax : prod_q[28:16];
		prev_ok = prev_q > lcse_pkg::PrevValidMv;
		up_d = {1'b0, mv} - {1'b0, prev_q};
		dn_d = {1'b0, prev_q} - {1'b0, mv};
		jump = prev_ok && mv >= prev_q && up_d >= 14'd150 && mv >= lcse_pkg::JumpMinMv;
		drop = prev_ok && prev_q >= mv && dn_d >= 14'd120;
		if (mv >= lcse_pkg::OnMv || jump) chg_next = 1'b1;
		else if (mv < lcse_pkg::OffMv || drop) chg_next = 1'b0;
		else chg_next = chg_q;
		start = chg_next && !chg_q;
		seg = 4'd9;
		for (int i = 8; i >= 0; i--) begin
			if (mv >= lcse_pkg::curve_mv(4'(i + 1))) seg = 4'(i);
		end
	end

	// finish step
	logic [6:0] frac;
	logic [31:0] inc;
	logic signed [7:0] chg_pct, base_eff, curve_res;
	logic [8:0] sum_pct;
	always_comb begin
		// round(pos*d/span): pos*d*2+span over 2*span; the step is at most 15
		frac = '0;
		for (int k = 0; k < 15; k++) begin
			if ({interp_q, 1'b0} + 16'(span_q) >= 16'(({1'b0, span_q, 1'b0}) * k + 2 * span_q))
				frac = 7'(k + 1);
		end
		if (clamp_hi_q) curve_res = 8'sd100;
		else if (clamp_lo_q) curve_res = 8'sd0;
		else curve_res = 8'(lo_pct_q + frac);
		inc = '0;
		for (int k = 1; k <= 99; k++) begin
			if (elapsed_q >= lcse_pkg::MsPerPct * 32'(k)) inc = 32'(k);
		end
		base_eff = (base_q >= 0) ? base_q : 8'sd0;
		sum_pct = 9'(base_eff) + 9'(inc[6:0]);
		if (inc >= 32'(lcse_pkg::ChargeCap) || sum_pct > 9'(lcse_pkg::ChargeCap))
			chg_pct = lcse_pkg::ChargeCap;
		else chg_pct = sum_pct[7:0];
	end

	assign sts.done_avg = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 18'd105626;
			known_q <= -8'sd1;
			stats_q <= 1'b1;
			interval_q <= 16'd300;
			sum_q <= '0;
			cnt_q <= '0;
			prev_q <= '0;
			chg_q <= 1'b0;
			cur_pct_q <= -8'sd1;
			base_q <= -8'sd1;
			start_q <= '0;
			cyc_q <= '0;
			sess_q <= '0;
			tot_q <= '0;
			last_save_q <= '0;
			percent <= -8'sd1;
			voltage_mv <= '0;
			charging <= 1'b0;
			updated <= 1'b0;
			cycles <= '0;
			session_seconds <= '0;
			total_seconds <= '0;
			save_request <= 1'b0;
			done_q <= 1'b0;
			upd_q <= 1'b0;
			save_q <= 1'b0;
			mv_q <= '0;
			elapsed_q <= '0;
			clamp_hi_q <= 1'b0;
			clamp_lo_q <= 1'b0;
			span_q <= '0;
			lo_pct_q <= '0;
			interp_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					lcse_pkg::REG_SCALE: scale_q <= cfg_data;
					lcse_pkg::REG_STORED: known_q <= cfg_pct;
					lcse_pkg::REG_STATS: stats_q <= cfg_data[0];
					lcse_pkg::REG_INTERVAL: interval_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				done_q <= 1'b0;
				if (!kind) begin
					if (cnt_q == CW'(lcse_pkg::AvgSamples - 1)) done_q <= 1'b1;
					sum_q <= sum_next;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.scale) begin
				upd_q <= done_q;
				save_q <= 1'b0;
				if (!done_q && kind_q && !chg_q) begin
					sess_q <= sess_q + 32'(secs_q);
					tot_q <= tot_q + 32'(secs_q);
					if (stats_q && (now_q - last_save_q) >= interval_ms_q) begin
						save_q <= 1'b1;
						last_save_q <= now_q;
					end
				end
				if (done_q) begin
					sum_q <= '0;
					cnt_q <= '0;
				end
			end
			if (cmd.decide) begin
				prev_q <= mv;
				mv_q <= mv;
				chg_q <= chg_next;
				if (start) begin
					if (cur_pct_q >= 0) base_q <= cur_pct_q;
					else if (known_q >= 0) base_q <= known_q;
					else base_q <= 8'sd0;
					start_q <= now_q;
					if (stats_q) begin
						cyc_q <= cyc_q + 1'b1;
						sess_q <= '0;
						save_q <= 1'b1;
						last_save_q <= now_q;
					end
				end
				elapsed_q <= now_q - (start ? now_q : start_q);
				clamp_hi_q <= mv >= 13'd4200;
				clamp_lo_q <= mv <= 13'd3000;
				span_q <= lcse_pkg::curve_mv(seg) - lcse_pkg::curve_mv(seg + 4'd1);
				lo_pct_q <= lcse_pkg::curve_pct(seg + 4'd1);
				interp_q <= 15'((mv - lcse_pkg::curve_mv(seg + 4'd1))
					* 13'(lcse_pkg::curve_pct(seg) - lcse_pkg::curve_pct(seg + 4'd1)));
			end
			if (cmd.finish) begin
				if (upd_q) begin
					voltage_mv <= mv_q;
					if (!chg_q) begin
						cur_pct_q <= curve_res;
						percent <= curve_res;
						base_q <= -8'sd1;
						known_q <= curve_res;
					end else begin
						cur_pct_q <= chg_pct;
						percent <= chg_pct;
					end
				end
				charging <= chg_q;
				updated <= upd_q;
				cycles <= cyc_q;
				session_seconds <= sess_q;
				total_seconds <= tot_q;
				save_request <= save_q;
			end
		end
	end

	// request payload and product register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			now_q <= now_ms;
			secs_q <= add_seconds;
			interval_ms_q <= 32'(interval_q) * 32'd1000;
		end
		if (cmd.scale) prod_q <= 30'(avg) * 30'(scale_q);
	end
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for lipo_charge_state_estimator: random and directed sample
// and runtime requests are checked against an in-bench charge state predictor.
// Depends on lcse_pkg and the lipo_charge_state_estimator RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int unsigned CURVE_MV [11] = '{4200, 4100, 4000, 3900, 3800, 3700, 3600,
		3500, 3400, 3300, 3000};
	localparam int CURVE_PCT [11] = '{100, 95, 88, 78, 65, 50, 35, 20, 10, 5, 0};

	typedef struct {
		bit          kind;
		logic [11:0] raw;
		logic [31:0] now;
		logic [15:0] secs;
	} soc_req_t;

	typedef struct {
		logic signed [7:0] pct;
		logic [12:0]       mv;
		bit                chg;
		bit                upd;
		logic [31:0]       cyc;
		logic [31:0]       ses;
		logic [31:0]       tot;
		bit                save;
	} soc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [17:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [11:0] raw_sample = '0;
	logic [31:0] now_ms = '0;
	logic [15:0] add_seconds = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] percent;
	logic [12:0] voltage_mv;
	logic charging;
	logic updated;
	logic [31:0] cycles;
	logic [31:0] session_seconds;
	logic [31:0] total_seconds;
	logic save_request;

	lipo_charge_state_estimator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state and register copies.
	int unsigned scale_q16, interval_s;
	bit stats_on;
	int unsigned acc_sum, acc_cnt, prev_mv, last_mv;
	bit charger_on;
	int soc_pct, base_pct, known_pct;
	int unsigned charge_t0, cycle_cnt, session_cnt, total_cnt, save_t0;

	soc_req_t pending_reqs[$];
	soc_result_t expected_results[$];
	bit in_taken = 1'b0;
	bit quiet = 1'b0;
	int send_gap = 0, recv_gap = 0, idle_cycles = 0;
	int mismatches = 0, n_reqs = 0, n_results = 0, n_updates = 0, n_saves = 0;
	int n_starts = 0;
	int unsigned clock_ms = 32'hFFF0_0000;
	int batt_mv = 3700;

	function automatic int curve_percent(int unsigned mv);
		int unsigned span, pos, d;
		if (mv >= CURVE_MV[0]) return 100;
		if (mv <= CURVE_MV[10]) return 0;
		for (int i = 0; i < 10; i++) begin
			if (mv >= CURVE_MV[i + 1]) begin
				span = CURVE_MV[i] - CURVE_MV[i + 1];
				pos = mv - CURVE_MV[i + 1];
				d = CURVE_PCT[i] - CURVE_PCT[i + 1];
				return CURVE_PCT[i + 1] + int'((2 * pos * d + span) / (2 * span));
			end
		end
		return 0;
	endfunction

	function automatic void reset_predictor();
		scale_q16 = 105626; interval_s = 300; stats_on = 1'b1;
		acc_sum = 0; acc_cnt = 0; prev_mv = 0; last_mv = 0; charger_on = 1'b0;
		soc_pct = -1; base_pct = -1; known_pct = -1;
		charge_t0 = 0; cycle_cnt = 0; session_cnt = 0; total_cnt = 0; save_t0 = 0;
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [17:0] data);
		int v;
		case (idx)
			lcse_pkg::REG_SCALE: scale_q16 = data;
			lcse_pkg::REG_STORED: begin
				v = int'($signed(data[7:0]));
				if (v < -1 || v > 100) v = -1;
				known_pct = v;
			end
			lcse_pkg::REG_STATS: stats_on = data[0];
			lcse_pkg::REG_INTERVAL: interval_s = data[15:0];
			default: ;
		endcase
	endfunction

	// Advance the charge state by one request and return the result it should give.
	function automatic soc_result_t predict_charge_state(soc_req_t r);
		soc_result_t res;
		longint unsigned prod;
		int unsigned mv, inc;
		int delta, p;
		bit jump, drop, was;
		res.upd = 1'b0;
		res.save = 1'b0;
		if (!r.kind) begin
			acc_sum += r.raw;
			acc_cnt++;
			if (acc_cnt >= 16) begin
				prod = (longint'(acc_sum / 16) * scale_q16) >> 16;
				mv = prod > 8191 ? 8191 : int'(prod);
				delta = prev_mv > 500 ? int'(mv) - int'(prev_mv) : 0;
				jump = delta >= 150 && mv >= 3900;
				drop = delta <= -120;
				was = charger_on;
				acc_sum = 0; acc_cnt = 0;
				res.upd = 1'b1;
				prev_mv = mv;
				if (mv >= 4180 || jump) charger_on = 1'b1;
				else if (mv < 4050 || drop) charger_on = 1'b0;
				if (charger_on && !was) begin
					n_starts++;
					base_pct = soc_pct >= 0 ? soc_pct : (known_pct >= 0 ? known_pct : 0);
					charge_t0 = r.now;
					if (stats_on) begin
						cycle_cnt++;
						session_cnt = 0;
						res.save = 1'b1;
						save_t0 = r.now;
					end
				end
				last_mv = mv;
				if (!charger_on) begin
					soc_pct = curve_percent(mv);
					base_pct = -1;
					known_pct = soc_pct;
				end else begin
					inc = (r.now - charge_t0) / 60000;
					p = inc >= 99 ? 99 : (base_pct >= 0 ? base_pct : 0) + int'(inc);
					soc_pct = p > 99 ? 99 : p;
				end
			end
		end else if (!charger_on) begin
			session_cnt += r.secs;
			total_cnt += r.secs;
			if (stats_on && (r.now - save_t0) >= interval_s * 1000) begin
				res.save = 1'b1;
				save_t0 = r.now;
			end
		end
		res.pct = soc_pct[7:0];
		res.mv = last_mv[12:0];
		res.chg = charger_on;
		res.cyc = cycle_cnt;
		res.ses = session_cnt;
		res.tot = total_cnt;
		return res;
	endfunction

	// Driver: present the next request at the falling edge, with random bursts of idling.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				kind <= pending_reqs[0].kind;
				raw_sample <= pending_reqs[0].raw;
				now_ms <= pending_reqs[0].now;
				add_seconds <= pending_reqs[0].secs;
				void'(pending_reqs.pop_front());
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
		// Stall the result side in bursts as well.
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 14);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		soc_result_t exp_r;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(predict_charge_state('{kind, raw_sample, now_ms,
				add_seconds}));
			n_reqs++;
		end
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("[%0t] result with no request pending", $realtime);
			end else begin
				exp_r = expected_results.pop_front();
				n_updates += updated;
				n_saves += save_request;
				if (percent !== exp_r.pct || voltage_mv !== exp_r.mv || charging !== exp_r.chg ||
						updated !== exp_r.upd || cycles !== exp_r.cyc ||
						session_seconds !== exp_r.ses || total_seconds !== exp_r.tot ||
						save_request !== exp_r.save) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] mismatch: pct %0d/%0d mv %0d/%0d chg %0d/%0d upd %0d/%0d",
							$realtime, exp_r.pct, percent, exp_r.mv, voltage_mv, exp_r.chg,
							charging, exp_r.upd, updated);
						$display("    cyc %0d/%0d ses %0d/%0d tot %0d/%0d save %0d/%0d (exp/act)",
							exp_r.cyc, cycles, exp_r.ses, session_seconds, exp_r.tot,
							total_seconds, exp_r.save, save_request);
					end
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_results.size());
			$display("** lipo_charge_state_estimator: FAILED **");
			$finish;
		end
	end

	task automatic push_req(bit k, logic [11:0] raw, logic [31:0] now, logic [15:0] secs);
		pending_reqs.push_back('{k, raw, now, secs});
	endtask

	// Convert a target voltage to an ADC code under the current scale.
	function automatic logic [11:0] code_for(int mv);
		longint unsigned c;
		if (scale_q16 == 0) return 12'($urandom_range(0, 4095));
		c = (longint'(mv) * 65536 + scale_q16 - 1) / scale_q16;
		return c > 4095 ? 12'hFFF : c[11:0];
	endfunction

	// Push one full averaging group around a target voltage, advancing the clock.
	task automatic push_group(int mv, int unsigned dt_ms);
		int c;
		for (int i = 0; i < 16; i++) begin
			c = int'(code_for(mv)) + $urandom_range(0, 6) - 3;
			c = c < 0 ? 0 : (c > 4095 ? 4095 : c);
			clock_ms += dt_ms / 16;
			push_req(1'b0, c[11:0], clock_ms, 16'($urandom));
		end
	endtask

	// Mostly well-formed battery traces; some noise and broken groups mixed in.
	task automatic push_random(int n);
		int start;
		int unsigned s;
		start = pending_reqs.size();
		while (pending_reqs.size() - start < n) begin
			case ($urandom_range(0, 9))
				0: push_req(1'($urandom_range(0, 1)), 12'($urandom), $urandom, 16'($urandom));
				1, 2: begin
					s = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) :
						$urandom_range(0, 400);
					clock_ms += s * 1000;
					push_req(1'b1, 12'($urandom), clock_ms, s[15:0]);
				end
				default: begin
					case ($urandom_range(0, 9))
						0: batt_mv = $urandom_range(4185, 4260);
						1: batt_mv += $urandom_range(150, 260);
						2: batt_mv -= $urandom_range(120, 300);
						3: batt_mv = $urandom_range(2900, 4300);
						default: batt_mv += $urandom_range(0, 60) - 40;
					endcase
					batt_mv = batt_mv < 2800 ? 2800 : (batt_mv > 4400 ? 4400 : batt_mv);
					push_group(batt_mv, $urandom_range(0, 200000));
				end
			endcase
		end
	endtask

	// Hold until every request has drained and the block has gone quiet.
	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [17:0] data);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		apply_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		reset_predictor();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, time added before any estimate, first group without
		// a previous voltage, then time added while charging is ignored.
		push_req(1'b1, 12'h000, 32'h0000_0000, 16'h0000);
		push_req(1'b1, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 16; i++) push_req(1'b0, i[0] ? 12'hFFF : 12'hFFE, 32'd1000, '0);
		push_req(1'b1, 12'h0, 32'd5000, 16'd100);
		wait_drained();

		// Full scale: saturate the voltage, then collapse it to zero.
		write_reg(lcse_pkg::REG_SCALE, 18'h3FFFF);
		push_group(9000, 1000);
		push_group(0, 1000);
		push_random(30);
		write_reg(lcse_pkg::REG_SCALE, 18'h0);
		push_random(20);
		write_reg(lcse_pkg::REG_SCALE, 18'd105626);
		write_reg(lcse_pkg::REG_STORED, 18'd100);
		push_random(70);
		write_reg(lcse_pkg::REG_STORED, 18'h000FB);
		write_reg(lcse_pkg::REG_STATS, 18'd0);
		push_random(70);
		write_reg(lcse_pkg::REG_STATS, 18'd1);
		write_reg(lcse_pkg::REG_INTERVAL, 18'd1);
		write_reg(lcse_pkg::REG_STORED, 18'd101);
		push_random(70);
		write_reg(lcse_pkg::REG_INTERVAL, 18'd0);
		write_reg(lcse_pkg::REG_STORED, 18'h00080);
		push_random(70);
		// Pause the sender until every expected result has come back.
		wait_drained();
		write_reg(lcse_pkg::REG_INTERVAL, 18'hFFFF);
		write_reg(lcse_pkg::REG_SCALE, 18'd98000);
		write_reg(lcse_pkg::REG_STORED, 18'h000FF);
		push_random(70);
		write_reg(lcse_pkg::REG_SCALE, 18'd110000);
		write_reg(lcse_pkg::REG_STORED, 18'd55);
		write_reg(lcse_pkg::REG_INTERVAL, 18'd300);
		push_random(70);
		// Last stretch at full rate: no idling on either side.
		wait_drained();
		quiet = 1'b1;
		push_random(150);
		wait_drained();

		$display("covered %0d requests, %0d results, %0d estimates, %0d charge starts",
			n_reqs, n_results, n_updates, n_starts);
		$display("%0d save requests seen over scale, stored percent, stats and interval sweeps",
			n_saves);
		if (mismatches == 0) begin
			$display("** lipo_charge_state_estimator: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** lipo_charge_state_estimator: FAILED **");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+sv
sv/lcse_pkg.sv
sv/lcse_ctrl.sv
sv/lcse_datapath.sv
sv/lipo_charge_state_estimator.sv
verif/testbench.sv
